/* rtl/refcpa_pkg.sv */
// ----------------------------------------------------------------------------
// refcpa_pkg
// Shared types and constants of the reference-counted page allocator.
// ----------------------------------------------------------------------------
package refcpa_pkg;

    // default geometry
    localparam int NUM_FRAMES_DEF = 65536;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int OP_W         = 3;
    localparam int PADDR_W      = 32;
    localparam int STATUS_W     = 3;
    localparam int REF_COUNT_W  = 16;
    localparam int FREE_PAGES_W = 17;

    // configuration registers
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_REG_W  = 29;

    localparam logic [CFG_REG_W-1:0] KERNEL_END_RST = 29'd0;
    localparam logic [CFG_REG_W-1:0] PHYS_TOP_RST   = 29'd234881024;

    localparam logic REG_KERNEL_END = 1'b0;
    localparam logic REG_PHYS_TOP   = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_SEED    = 3'd0,
        OP_ALLOC   = 3'd1,
        OP_FREE    = 3'd2,
        OP_INC_REF = 3'd3,
        OP_DEC_REF = 3'd4,
        OP_GET_REF = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_BAD_ADDR    = 3'd1,
        STAT_NO_MEM      = 3'd2,
        STAT_DOUBLE_FREE = 3'd3,
        STAT_OVERFLOW    = 3'd4,
        STAT_UNDERFLOW   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CS_CLEAR = 2'd0,
        CS_IDLE  = 2'd1,
        CS_EXEC  = 2'd2
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // take the input word, start table reads
        logic commit;    // write back and load the result register
        logic clear_wr;  // clear one count entry
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } dp_stat_t;

endpackage

/* rtl/refcpa_ram.sv */
// ----------------------------------------------------------------------------
// refcpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module refcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/refcpa_ctrl.sv */
// ----------------------------------------------------------------------------
// refcpa_ctrl
// Sequencer: count table clearing pass, word accept, execute and result slot.
// ----------------------------------------------------------------------------
module refcpa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output refcpa_pkg::ctl_cmd_t  cmd,
    input  refcpa_pkg::dp_stat_t  stat
);

    import refcpa_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // result slot can take a word when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.commit   = 1'b0;
        cmd.clear_wr = 1'b0;
        unique case (state_reg)
            CS_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            CS_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            CS_EXEC:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/refcpa_dp.sv */
// ----------------------------------------------------------------------------
// refcpa_dp
// Datapath: config registers, free stack and count table RAMs, stack depth,
// request evaluation and result register.
// ----------------------------------------------------------------------------
module refcpa_dp #(
    parameter int NUM_FRAMES = refcpa_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_SHIFT = refcpa_pkg::PAGE_SHIFT_DEF,
    parameter int COUNT_BITS = refcpa_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  refcpa_pkg::ctl_cmd_t                 cmd,
    output refcpa_pkg::dp_stat_t                 stat,
    // config port
    input  logic                                 cfg_wr,
    input  logic [refcpa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [refcpa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic [refcpa_pkg::CFG_DATA_W-1:0]    cfg_rdata,
    // request word
    input  logic [refcpa_pkg::OP_W-1:0]          operation,
    input  logic [refcpa_pkg::PADDR_W-1:0]       page_addr,
    // result word
    output logic [refcpa_pkg::STATUS_W-1:0]      status,
    output logic [refcpa_pkg::PADDR_W-1:0]       alloc_addr,
    output logic [refcpa_pkg::REF_COUNT_W-1:0]   ref_count,
    output logic                                 page_released,
    output logic [refcpa_pkg::FREE_PAGES_W-1:0]  pages_free
);

    import refcpa_pkg::*;

    localparam int FW      = $clog2(NUM_FRAMES);
    localparam int DW      = $clog2(NUM_FRAMES + 1);
    localparam int FRAME_W = PADDR_W - PAGE_SHIFT;
    localparam int WIDE_W  = FW + PAGE_SHIFT;

    // config registers
    logic [CFG_REG_W-1:0] kend_reg;
    logic [CFG_REG_W-1:0] ptop_reg;
    logic                 cfg_idx;

    assign cfg_idx = cfg_addr[CFG_ADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kend_reg <= KERNEL_END_RST;
            ptop_reg <= PHYS_TOP_RST;
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == REG_KERNEL_END)
            begin
                kend_reg <= cfg_wdata[CFG_REG_W-1:0];
            end
            else
            begin
                ptop_reg <= cfg_wdata[CFG_REG_W-1:0];
            end
        end
    end

    assign cfg_rdata = (cfg_idx == REG_KERNEL_END) ? CFG_DATA_W'(kend_reg)
                                                   : CFG_DATA_W'(ptop_reg);

    // request registers
    op_t                op_reg;
    logic [PADDR_W-1:0] addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(operation);
            addr_reg <= page_addr;
        end
    end

    // stack depth and clearing counter
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [FW-1:0] clr_cnt_reg;
    logic [FW-1:0] clr_cnt_next;

    assign clr_cnt_next    = clr_cnt_reg + FW'(1);
    assign stat.clear_last = (clr_cnt_reg == FW'(NUM_FRAMES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                depth_reg <= depth_next;
            end
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_next;
            end
        end
    end

    // memories
    logic                  ref_we;
    logic [FW-1:0]         ref_waddr;
    logic [COUNT_BITS-1:0] ref_wdata;
    logic [COUNT_BITS-1:0] ref_rdata;
    logic                  stk_we;
    logic [FW-1:0]         stk_rdata;
    logic [FW-1:0]         in_frame;
    logic [FW-1:0]         top_idx;

    assign in_frame = FW'(page_addr[PADDR_W-1:PAGE_SHIFT]);
    // top of stack sits one below the depth
    assign top_idx  = FW'(depth_reg - DW'(1));

    refcpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_FRAMES)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .re    (cmd.load),
        .raddr (in_frame),
        .rdata (ref_rdata)
    );

    refcpa_ram #(
        .WIDTH (FW),
        .DEPTH (NUM_FRAMES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (FW'(depth_reg)),
        .wdata (FW'(addr_reg[PADDR_W-1:PAGE_SHIFT])),
        .re    (cmd.load),
        .raddr (top_idx),
        .rdata (stk_rdata)
    );

    // request evaluation
    logic [FRAME_W-1:0]    frame_raw;
    logic [FW-1:0]         frame_idx;
    logic                  aligned;
    logic                  range_ok;
    logic                  addr_ok;
    logic                  stack_full;
    logic                  stack_empty;
    logic [WIDE_W-1:0]     alloc_wide;
    status_t               res_status;
    logic [PADDR_W-1:0]    res_alloc;
    logic [COUNT_BITS-1:0] res_count;
    logic                  res_released;
    logic                  upd_we;
    logic [FW-1:0]         upd_addr;
    logic [COUNT_BITS-1:0] upd_data;
    logic                  push;

    assign frame_raw   = addr_reg[PADDR_W-1:PAGE_SHIFT];
    assign frame_idx   = FW'(frame_raw);
    assign aligned     = (addr_reg[PAGE_SHIFT-1:0] == '0);
    assign range_ok    = (addr_reg >= PADDR_W'(kend_reg))
                      && (addr_reg < PADDR_W'(ptop_reg))
                      && ((PADDR_W + 1)'(frame_raw) < (PADDR_W + 1)'(NUM_FRAMES));
    assign stack_full  = (depth_reg == DW'(NUM_FRAMES));
    assign stack_empty = (depth_reg == '0);
    assign alloc_wide  = {stk_rdata, {PAGE_SHIFT{1'b0}}};

    always_comb
    begin
        addr_ok = range_ok;
        if (op_reg == OP_SEED || op_reg == OP_FREE)
        begin
            addr_ok = range_ok && aligned;
        end
    end

    always_comb
    begin
        res_status   = STAT_OK;
        res_alloc    = '0;
        res_count    = '0;
        res_released = 1'b0;
        upd_we       = 1'b0;
        upd_addr     = frame_idx;
        upd_data     = '0;
        push         = 1'b0;
        depth_next   = depth_reg;
        unique case (op_reg)
            OP_SEED:
            begin
                if (!addr_ok)
                begin
                    res_status = STAT_BAD_ADDR;
                end
                else if (stack_full)
                begin
                    res_status = STAT_OVERFLOW;
                    res_count  = ref_rdata;
                end
                else
                begin
                    upd_we       = 1'b1;
                    push         = 1'b1;
                    res_released = 1'b1;
                end
            end
            OP_ALLOC:
            begin
                if (stack_empty)
                begin
                    res_status = STAT_NO_MEM;
                end
                else
                begin
                    depth_next = depth_reg - DW'(1);
                    upd_we     = 1'b1;
                    upd_addr   = stk_rdata;
                    upd_data   = COUNT_BITS'(1);
                    res_count  = COUNT_BITS'(1);
                    res_alloc  = PADDR_W'(alloc_wide);
                end
            end
            OP_FREE, OP_DEC_REF:
            begin
                if (!addr_ok)
                begin
                    res_status = STAT_BAD_ADDR;
                end
                else if (ref_rdata == '0)
                begin
                    res_status = (op_reg == OP_FREE) ? STAT_DOUBLE_FREE : STAT_UNDERFLOW;
                end
                else if (ref_rdata == COUNT_BITS'(1))
                begin
                    if (stack_full)
                    begin
                        res_status = STAT_OVERFLOW;
                        res_count  = ref_rdata;
                    end
                    else
                    begin
                        upd_we       = 1'b1;
                        push         = 1'b1;
                        res_released = 1'b1;
                    end
                end
                else
                begin
                    upd_we    = 1'b1;
                    upd_data  = ref_rdata - COUNT_BITS'(1);
                    res_count = ref_rdata - COUNT_BITS'(1);
                end
            end
            OP_INC_REF:
            begin
                if (!addr_ok)
                begin
                    res_status = STAT_BAD_ADDR;
                end
                else if (&ref_rdata)
                begin
                    res_status = STAT_OVERFLOW;
                    res_count  = ref_rdata;
                end
                else
                begin
                    upd_we    = 1'b1;
                    upd_data  = ref_rdata + COUNT_BITS'(1);
                    res_count = ref_rdata + COUNT_BITS'(1);
                end
            end
            OP_GET_REF:
            begin
                if (!addr_ok)
                begin
                    res_status = STAT_BAD_ADDR;
                end
                else
                begin
                    res_count = ref_rdata;
                end
            end
            default:
            begin
                res_status = STAT_OK;
            end
        endcase
        if (push)
        begin
            depth_next = depth_reg + DW'(1);
        end
    end

    // clearing pass owns the count table write port until it ends
    always_comb
    begin
        if (cmd.clear_wr)
        begin
            ref_we    = 1'b1;
            ref_waddr = clr_cnt_reg;
            ref_wdata = '0;
        end
        else
        begin
            ref_we    = cmd.commit && upd_we;
            ref_waddr = upd_addr;
            ref_wdata = upd_data;
        end
    end

    assign stk_we = cmd.commit && push;

    // result register
    status_t            status_reg;
    logic [PADDR_W-1:0] alloc_reg;
    logic [31:0]        count_ext;
    logic [REF_COUNT_W-1:0] count_reg;
    logic               released_reg;
    logic [FREE_PAGES_W-1:0] free_reg;

    assign count_ext = 32'(res_count);

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg   <= res_status;
            alloc_reg    <= res_alloc;
            count_reg    <= count_ext[REF_COUNT_W-1:0];
            released_reg <= res_released;
            free_reg     <= FREE_PAGES_W'(depth_next);
        end
    end

    assign status        = status_reg;
    assign alloc_addr    = alloc_reg;
    assign ref_count     = count_reg;
    assign page_released = released_reg;
    assign pages_free    = free_reg;

endmodule

/* rtl/refcounted_page_allocator_core.sv */
// ----------------------------------------------------------------------------
// refcounted_page_allocator_core
// Page frame allocator with a LIFO free stack and per-frame reference counts.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  request  in_valid / in_ready    operation, page_addr
//  result   out_valid / out_ready  status, alloc_addr, ref_count,
//                                  page_released, pages_free
//  config   psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
//  a request is accepted in idle, which starts the count table and free stack
//  reads; the execute state evaluates and writes the RAMs back as needed
//  after reset all NUM_FRAMES count table entries (65536 by default) are
//  cleared one entry a cycle, with in_ready low until it completes
//  a held result word stalls the execute cycle until out_ready
// ----------------------------------------------------------------------------
module refcounted_page_allocator_core #(
    parameter int NUM_FRAMES = refcpa_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_SHIFT = refcpa_pkg::PAGE_SHIFT_DEF,
    parameter int COUNT_BITS = refcpa_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [refcpa_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [refcpa_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [refcpa_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                 pready,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [refcpa_pkg::OP_W-1:0]          operation,
    input  logic [refcpa_pkg::PADDR_W-1:0]       page_addr,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [refcpa_pkg::STATUS_W-1:0]      status,
    output logic [refcpa_pkg::PADDR_W-1:0]       alloc_addr,
    output logic [refcpa_pkg::REF_COUNT_W-1:0]   ref_count,
    output logic                                 page_released,
    output logic [refcpa_pkg::FREE_PAGES_W-1:0]  pages_free
);

    import refcpa_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;
    logic     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    refcpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    refcpa_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr        (cfg_wr),
        .cfg_addr      (paddr),
        .cfg_wdata     (pwdata),
        .cfg_rdata     (prdata),
        .operation     (operation),
        .page_addr     (page_addr),
        .status        (status),
        .alloc_addr    (alloc_addr),
        .ref_count     (ref_count),
        .page_released (page_released),
        .pages_free    (pages_free)
    );

endmodule
